### rtl/tls_client_hello_sni_parser_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the TLS ClientHello SNI parser.
// Both forms compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TLS_CLIENT_HELLO_SNI_PARSER_TOP_MACROS_SVH
`define TLS_CLIENT_HELLO_SNI_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define TCSP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tcsp assertion failed");
// Check a property on every rising edge, reset included.
`define TCSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcsp assertion failed");
`else
`define TCSP_ASSERT(lbl, clk, rst, prop)
`define TCSP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/tcsp_pkg.sv
// ---------------------------------------------------------------------------
// tcsp_pkg
// Shared types and constants of the TLS ClientHello SNI parser.
// ---------------------------------------------------------------------------
`default_nettype none

package tcsp_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NEED_MORE = 2'd1;
  localparam logic [1:0] ST_NO_SNI    = 2'd2;
  localparam logic [1:0] ST_BAD       = 2'd3;

  localparam logic [7:0]  HELLO_TYPE = 8'h01;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_DOT     = 8'h2E;
  localparam logic [15:0] FIXED_LEN  = 16'd34;
  localparam logic [23:0] MIN_BODY   = 24'd35;
  localparam logic [15:0] CAP_RESET  = 16'd256;

  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  host_byte;
    logic [1:0]  status;
    logic [15:0] host_length;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage

`default_nettype wire

### rtl/tcsp_parser.sv
// ---------------------------------------------------------------------------
// tcsp_parser
// Byte-serial ClientHello walker: one byte per step, up to two results.
// ---------------------------------------------------------------------------
`default_nettype none

module tcsp_parser #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [15:0]       host_capacity,
  output tcsp_pkg::step_out_t    step_out
);
  import tcsp_pkg::*;

  localparam int P = POSITION_BITS;
  localparam int W = POSITION_BITS + 2;

  localparam logic [4:0] PH_HDR0 = 5'd0,  PH_HDR1 = 5'd1,  PH_HDR2 = 5'd2;
  localparam logic [4:0] PH_HDR3 = 5'd3,  PH_FIXED = 5'd4, PH_SID_LEN = 5'd5;
  localparam logic [4:0] PH_SID = 5'd6,   PH_CS0 = 5'd7,   PH_CS1 = 5'd8;
  localparam logic [4:0] PH_CS = 5'd9,    PH_CM_LEN = 5'd10, PH_CM = 5'd11;
  localparam logic [4:0] PH_EXTS0 = 5'd12, PH_EXTS1 = 5'd13, PH_EXT_T0 = 5'd14;
  localparam logic [4:0] PH_EXT_T1 = 5'd15, PH_EXT_L0 = 5'd16, PH_EXT_L1 = 5'd17;
  localparam logic [4:0] PH_EXT_SKIP = 5'd18, PH_SNI_L0 = 5'd19, PH_SNI_L1 = 5'd20;
  localparam logic [4:0] PH_LIST0 = 5'd21, PH_LIST1 = 5'd22, PH_NAME_TYPE = 5'd23;
  localparam logic [4:0] PH_NAME_L0 = 5'd24, PH_NAME_L1 = 5'd25;
  localparam logic [4:0] PH_NAME_SKIP = 5'd26, PH_NAME_VALUE = 5'd27;
  localparam logic [4:0] PH_DRAIN = 5'd28, PH_DONE = 5'd29;

  typedef struct packed {
    logic [4:0] ph;
    logic       dec;
    logic [1:0] st;
  } goto_t;

  // where to go once a skip or a field run ends
  function automatic goto_t after_skip(input logic [4:0] ph, input logic [W-1:0] p,
                                       input logic [W-1:0] e, input logic [W-1:0] xe,
                                       input logic [W-1:0] nle);
    goto_t g;
    g = '{ph: PH_DRAIN, dec: 1'b0, st: ST_OK};
    case (ph)
      PH_FIXED: g.ph = PH_SID_LEN;
      PH_SID:   g.ph = PH_CS0;
      PH_CS:    g.ph = PH_CM_LEN;
      PH_CM: begin
        if (p == e) begin
          g.dec = 1'b1; g.st = ST_NO_SNI;
        end else if (e < p + W'(2)) begin
          g.dec = 1'b1; g.st = ST_BAD;
        end else begin
          g.ph = PH_EXTS0;
        end
      end
      PH_EXT_SKIP: begin
        if (p + W'(4) <= xe) begin
          g.ph = PH_EXT_T0;
        end else begin
          g.dec = 1'b1; g.st = (p == xe) ? ST_NO_SNI : ST_BAD;
        end
      end
      default: begin
        if (p + W'(3) <= nle) begin
          g.ph = PH_NAME_TYPE;
        end else begin
          g.dec = 1'b1; g.st = ST_NO_SNI;
        end
      end
    endcase
    return g;
  endfunction

  logic [4:0]   phase, phase_next;
  logic [P-1:0] pos, pos_next, hs_end, hs_end_next;
  logic [23:0]  acc, acc_next;
  logic [15:0]  skip, skip_next;
  logic [P-1:0] exts_end, exts_end_next, ext_end, ext_end_next;
  logic [P-1:0] list_end, list_end_next, value_end, value_end_next;
  logic [15:0]  name_count, name_count_next, dot_end, dot_end_next;
  logic [15:0]  non_dot_end, non_dot_end_next;
  logic [1:0]   dec_status, dec_status_next;
  logic         dec_flag, dec_flag_next, verdict_sent, verdict_sent_next;

  logic         echo, ready, fire_v, need;
  goto_t        g;
  logic         go;
  logic [P-1:0] pos1;
  logic [W-1:0] pw, ew, bw, nw, xew, sum;
  logic [15:0]  n16, cnt, t;
  logic [23:0]  len24;
  logic         finish;
  result_t      r_echo, r_verd, r_need;

  always_comb begin
    phase_next = phase; pos_next = pos; hs_end_next = hs_end; acc_next = acc;
    skip_next = skip; exts_end_next = exts_end; ext_end_next = ext_end;
    list_end_next = list_end; value_end_next = value_end;
    name_count_next = name_count; dot_end_next = dot_end;
    non_dot_end_next = non_dot_end; dec_status_next = dec_status;
    dec_flag_next = dec_flag; verdict_sent_next = verdict_sent;
    echo = 1'b0; ready = 1'b0; go = 1'b0; finish = 1'b0;
    g = '{ph: PH_DRAIN, dec: 1'b0, st: ST_OK};
    pos1 = pos + P'(1);
    pw = W'(pos1); ew = W'(hs_end); bw = W'(data_byte);
    n16 = {acc[7:0], data_byte}; nw = W'(n16); xew = W'(exts_end);
    sum = pw + nw; cnt = name_count + 16'd1; t = dot_end;
    len24 = {acc[15:0], data_byte};

    unique case (phase)
      PH_HDR0: begin
        if (data_byte != HELLO_TYPE) begin
          dec_flag_next = 1'b1; dec_status_next = ST_BAD;
        end
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        acc_next = {16'd0, data_byte}; phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        acc_next = {acc[15:0], data_byte}; phase_next = PH_HDR3;
      end
      PH_HDR3: begin
        if (dec_flag || ((len24 >> P) != 24'd0)) begin
          go = 1'b1; g.dec = 1'b1; g.st = ST_BAD; ready = 1'b1;
        end else begin
          hs_end_next = len24[P-1:0];
          if (len24 < MIN_BODY) begin
            go = 1'b1; g.dec = 1'b1; g.st = ST_BAD;
          end else begin
            skip_next = FIXED_LEN; phase_next = PH_FIXED;
          end
          ready = (len24 == 24'd0);
        end
      end
      PH_DONE: ;
      default: begin
        pos_next = pos1;
        ready = (pos1 == hs_end);
        unique case (phase)
          PH_FIXED, PH_SID, PH_CS, PH_CM, PH_EXT_SKIP, PH_NAME_SKIP: begin
            skip_next = skip - 16'd1;
            if (skip_next == 16'd0) begin
              go = 1'b1; g = after_skip(phase, pw, ew, xew, W'(list_end));
            end
          end
          PH_SID_LEN: begin
            go = 1'b1;
            if (ew < pw + bw + W'(2)) begin
              g.dec = 1'b1; g.st = ST_BAD;
            end else begin
              skip_next = 16'(data_byte);
              if (data_byte == 8'd0) g = after_skip(PH_SID, pw, ew, xew, W'(list_end));
              else g.ph = PH_SID;
            end
          end
          PH_CS0, PH_EXTS0, PH_EXT_T0, PH_EXT_L0, PH_SNI_L0, PH_LIST0: begin
            acc_next = {16'd0, data_byte}; phase_next = phase + 5'd1;
          end
          PH_CS1: begin
            go = 1'b1;
            if (ew < sum + W'(1)) begin
              g.dec = 1'b1; g.st = ST_BAD;
            end else begin
              skip_next = n16;
              if (n16 == 16'd0) g = after_skip(PH_CS, pw, ew, xew, W'(list_end));
              else g.ph = PH_CS;
            end
          end
          PH_CM_LEN: begin
            go = 1'b1;
            if (ew < pw + bw) begin
              g.dec = 1'b1; g.st = ST_BAD;
            end else begin
              skip_next = 16'(data_byte);
              if (data_byte == 8'd0) g = after_skip(PH_CM, pw, ew, xew, W'(list_end));
              else g.ph = PH_CM;
            end
          end
          PH_EXTS1: begin
            go = 1'b1;
            if (ew < sum) begin
              g.dec = 1'b1; g.st = ST_BAD;
            end else begin
              exts_end_next = sum[P-1:0];
              g = after_skip(PH_EXT_SKIP, pw, ew, sum, W'(list_end));
            end
          end
          PH_EXT_T1: phase_next = (n16 == 16'd0) ? PH_SNI_L0 : PH_EXT_L0;
          PH_EXT_L1: begin
            go = 1'b1;
            if (sum > xew) begin
              g.dec = 1'b1; g.st = ST_BAD;
            end else begin
              skip_next = n16;
              if (n16 == 16'd0) g = after_skip(PH_EXT_SKIP, pw, ew, xew, W'(list_end));
              else g.ph = PH_EXT_SKIP;
            end
          end
          PH_SNI_L1: begin
            if (sum > xew || n16 < 16'd2) begin
              go = 1'b1; g.dec = 1'b1; g.st = ST_BAD;
            end else begin
              ext_end_next = sum[P-1:0]; phase_next = PH_LIST0;
            end
          end
          PH_LIST1: begin
            go = 1'b1;
            list_end_next = sum[P-1:0];
            if (sum > W'(ext_end)) begin
              g.dec = 1'b1; g.st = ST_BAD;
            end else begin
              g = after_skip(PH_NAME_SKIP, pw, ew, xew, sum);
            end
          end
          PH_NAME_TYPE: begin
            acc_next = {data_byte, 16'd0}; phase_next = PH_NAME_L0;
          end
          PH_NAME_L0: begin
            acc_next = {acc[23:16], data_byte, 8'd0}; phase_next = PH_NAME_L1;
          end
          PH_NAME_L1: begin
            acc_next = {acc[23:8], data_byte};
            n16 = {acc[15:8], data_byte};
            nw = W'(n16); sum = pw + nw;
            if (sum > W'(list_end)) begin
              go = 1'b1; g.dec = 1'b1; g.st = ST_BAD;
            end else if (acc[23:16] == 8'd0) begin
              value_end_next = sum[P-1:0];
              name_count_next = 16'd0; dot_end_next = 16'd0; non_dot_end_next = 16'd0;
              t = 16'd0;
              if (n16 == 16'd0) finish = 1'b1;
              else phase_next = PH_NAME_VALUE;
            end else begin
              go = 1'b1; skip_next = n16;
              if (n16 == 16'd0) g = after_skip(PH_NAME_SKIP, pw, ew, xew, W'(list_end));
              else g.ph = PH_NAME_SKIP;
            end
          end
          PH_NAME_VALUE: begin
            name_count_next = cnt;
            if (data_byte != CH_SPACE && data_byte != CH_TAB && data_byte != CH_CR) begin
              dot_end_next = (data_byte != CH_DOT) ? cnt : non_dot_end;
            end
            if (data_byte != CH_DOT) non_dot_end_next = cnt;
            echo = 1'b1;
            t = dot_end_next;
            if (pos1 == value_end) finish = 1'b1;
          end
          default: ;
        endcase
      end
    endcase

    // trimmed length decides ok or no_sni
    if (finish) begin
      go = 1'b1; g.dec = 1'b1;
      g.st = (t == 16'd0 || t >= host_capacity) ? ST_NO_SNI : ST_OK;
    end
    if (go) begin
      if (g.dec) begin
        dec_flag_next = 1'b1; dec_status_next = g.st; phase_next = PH_DRAIN;
      end else begin
        phase_next = g.ph;
      end
    end

    fire_v = ready && !verdict_sent;
    r_echo = '{is_verdict: 1'b0, host_byte: data_byte, status: ST_OK,
               host_length: 16'd0, last_of_run: 1'b0};
    r_verd.is_verdict  = 1'b1;
    r_verd.host_byte   = 8'd0;
    r_verd.status      = dec_flag_next ? dec_status_next : ST_BAD;
    r_verd.host_length = (r_verd.status == ST_OK) ? dot_end_next : 16'd0;
    r_verd.last_of_run = 1'b0;
    r_need = '{is_verdict: 1'b1, host_byte: 8'd0, status: ST_NEED_MORE,
               host_length: 16'd0, last_of_run: 1'b0};
    if (fire_v) begin
      verdict_sent_next = 1'b1; phase_next = PH_DONE;
    end
    need = last_byte && !verdict_sent_next;

    step_out = '0;
    if (echo) begin
      step_out.first = r_echo;
      if (fire_v) begin
        step_out.second = r_verd; step_out.count = 2'd2;
      end else if (need) begin
        step_out.second = r_need; step_out.count = 2'd2;
      end else begin
        step_out.count = 2'd1;
      end
    end else if (fire_v) begin
      step_out.first = r_verd; step_out.count = 2'd1;
    end else if (need) begin
      step_out.first = r_need; step_out.count = 2'd1;
    end
    if (step_out.count == 2'd2) step_out.second.last_of_run = 1'b1;
    else step_out.first.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase <= PH_HDR0; pos <= '0; hs_end <= '0; acc <= '0; skip <= '0;
      exts_end <= '0; ext_end <= '0; list_end <= '0; value_end <= '0;
      name_count <= '0; dot_end <= '0; non_dot_end <= '0;
      dec_status <= ST_OK; dec_flag <= 1'b0; verdict_sent <= 1'b0;
    end else if (step) begin
      phase <= phase_next; pos <= pos_next; hs_end <= hs_end_next;
      acc <= acc_next; skip <= skip_next; exts_end <= exts_end_next;
      ext_end <= ext_end_next; list_end <= list_end_next;
      value_end <= value_end_next; name_count <= name_count_next;
      dot_end <= dot_end_next; non_dot_end <= non_dot_end_next;
      dec_status <= dec_status_next; dec_flag <= dec_flag_next;
      verdict_sent <= verdict_sent_next;
    end
  end

endmodule

`default_nettype wire

### rtl/tls_client_hello_sni_parser_top.sv
// ---------------------------------------------------------------------------
// tls_client_hello_sni_parser_top
// Streaming server-name extractor for a TLS ClientHello handshake message.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, data_byte, last_byte) carries one
//   message byte per transaction; last_byte marks the final available byte
//   and returns the parser to its start state afterwards.
//   Output channel (out_valid/out_ready) carries host name echoes and one
//   verdict per message; a byte gives zero, one or two results.
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes host_capacity;
//   write it only while the block is idle. cfg_ready is always high.
// Throughput: one byte per cycle while in_ready is high; a byte yielding
//   two results drains through the four-entry output queue, which stalls
//   input only when nearly full.
// Reset: rst (synchronous) clears the parser and queue and loads
//   host_capacity with 256.
// Receiver stall: results wait in the queue; in_ready drops once fewer
//   than two free entries remain.
// ---------------------------------------------------------------------------
`default_nettype none

module tls_client_hello_sni_parser_top #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_verdict,
  output logic [7:0]       host_byte,
  output logic [1:0]       status,
  output logic [15:0]      host_length,
  output logic             last_of_run,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import tcsp_pkg::*;
  `include "tls_client_hello_sni_parser_top_macros.svh"

  localparam int FIFO_DEPTH = 4;

  logic [15:0] host_capacity;
  step_out_t   step_out;
  logic        in_acc, pop;
  result_t     queue [FIFO_DEPTH];
  logic [1:0]  wp, rp;
  logic [2:0]  count, count_next;
  result_t     head;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  // keep room for the two results a byte can produce
  assign in_ready  = (count <= 3'(FIFO_DEPTH - 2));
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;

  // hold the capacity register; load on a config transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      host_capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      host_capacity <= cfg_data;
    end
  end

  tcsp_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (in_acc),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .host_capacity(host_capacity),
    .step_out     (step_out)
  );

  always_comb begin
    count_next = count;
    if (in_acc) count_next = count_next + 3'(step_out.count);
    if (pop) count_next = count_next - 3'd1;
  end

  // push up to two results, advance the read side on each output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      count <= count_next;
      if (pop) rp <= rp + 2'd1;
      if (in_acc) wp <= wp + step_out.count;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && step_out.count != 2'd0) queue[wp] <= step_out.first;
    if (in_acc && step_out.count == 2'd2) queue[wp + 2'd1] <= step_out.second;
  end

  assign head        = queue[rp];
  assign is_verdict  = head.is_verdict;
  assign host_byte   = head.host_byte;
  assign status      = head.status;
  assign host_length = head.host_length;
  assign last_of_run = head.last_of_run;

  `TCSP_ASSERT(a_count_bound, clk, rst, count <= 3'(FIFO_DEPTH))
  `TCSP_ASSERT(a_pop_only, clk, rst, (!in_acc && pop) |=> count == $past(count) - 3'd1)
  `TCSP_ASSERT(a_push_two, clk, rst, (in_acc && !pop && step_out.count == 2'd2) |=> count == $past(count) + 3'd2)

endmodule

`default_nettype wire

### tb/tls_client_hello_sni_parser_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TLS ClientHello SNI parser testbench
// Feeds handshake byte streams (short hand-made headers, then random
// ClientHello messages: well formed, corrupted, cut short, padded with junk
// or pure noise) through the byte channel under several host_capacity settings.
// A cycle-level predictor of the parser produces the expected name echoes
// and verdicts, and every transaction on the result channel is checked.
// ---------------------------------------------------------------------------
module tls_client_hello_sni_parser_top_test;
  import tcsp_pkg::*;

  localparam int unsigned POS_MASK = 32'h00FF_FFFF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef enum int {
    P_HDR0, P_HDR1, P_HDR2, P_HDR3, P_FIXED, P_SID_LEN, P_SID,
    P_CS0, P_CS1, P_CS, P_CM_LEN, P_CM, P_EXTS0, P_EXTS1,
    P_EXT_T0, P_EXT_T1, P_EXT_L0, P_EXT_L1, P_EXT_SKIP,
    P_SNI_L0, P_SNI_L1, P_LIST0, P_LIST1, P_NAME_TYPE, P_NAME_L0,
    P_NAME_L1, P_NAME_SKIP, P_NAME_VALUE, P_DRAIN, P_DONE
  } hello_phase_e;

  typedef struct {
    bit [7:0] data;
    bit       last;
  } msg_byte_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        is_verdict;
  logic [7:0]  host_byte;
  logic [1:0]  status;
  logic [15:0] host_length;
  logic        last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Bytes waiting to be offered and results the parser still owes us.
  msg_byte_t byte_q[$];
  result_t   results_due[$];

  int errors = 0;
  int cycles = 0;
  int in_count = 0;
  int out_count = 0;
  bit in_took = 0;

  // Predictor copy of the parser state and the capacity register.
  bit [31:0]    cap_shadow = CAP_RESET;
  hello_phase_e hs_phase = P_HDR0;
  bit [31:0]    body_pos, body_end, accum, skip_left;
  bit [31:0]    exts_end, ext_end, list_end, value_end;
  bit [31:0]    name_cnt, space_end, dot_end, nondot_end;
  bit [1:0]     dec_status;
  bit           dec_flag, verdict_done;

  tls_client_hello_sni_parser_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_verdict  (is_verdict),
    .host_byte   (host_byte),
    .status      (status),
    .host_length (host_length),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // ------------------------------------------------------------------------
  // Parser predictor
  // ------------------------------------------------------------------------
  function automatic void clear_parse();
    hs_phase = P_HDR0;
    body_pos = 0; body_end = 0; accum = 0; skip_left = 0;
    exts_end = 0; ext_end = 0; list_end = 0; value_end = 0;
    name_cnt = 0; space_end = 0; dot_end = 0; nondot_end = 0;
    dec_status = ST_OK; dec_flag = 0; verdict_done = 0;
  endfunction

  function automatic void decide(bit [1:0] st);
    dec_flag = 1;
    dec_status = st;
    hs_phase = P_DRAIN;
  endfunction

  function automatic void ext_loop();
    if (body_pos + 4 <= exts_end) hs_phase = P_EXT_T0;
    else decide(body_pos == exts_end ? ST_NO_SNI : ST_BAD);
  endfunction

  function automatic void name_loop();
    if (body_pos + 3 <= list_end) hs_phase = P_NAME_TYPE;
    else decide(ST_NO_SNI);
  endfunction

  function automatic void after_skip(hello_phase_e ph);
    case (ph)
      P_FIXED: hs_phase = P_SID_LEN;
      P_SID:   hs_phase = P_CS0;
      P_CS:    hs_phase = P_CM_LEN;
      P_CM: begin
        // No extension block at all means no server name.
        if (body_pos == body_end) decide(ST_NO_SNI);
        else if (body_end < body_pos + 2) decide(ST_BAD);
        else hs_phase = P_EXTS0;
      end
      P_EXT_SKIP: ext_loop();
      default: name_loop();
    endcase
  endfunction

  function automatic void skip_or_go(bit [31:0] n, hello_phase_e ph);
    skip_left = n;
    if (n == 0) after_skip(ph);
    else hs_phase = ph;
  endfunction

  function automatic void finish_name();
    if (dot_end == 0 || dot_end >= cap_shadow) decide(ST_NO_SNI);
    else decide(ST_OK);
  endfunction

  // Advance over one body byte; return 1 when the byte is a name echo.
  function automatic bit consume_body(bit [31:0] b);
    bit [31:0] p;
    bit [31:0] n;
    body_pos = (body_pos + 1) & POS_MASK;
    p = body_pos;
    n = (accum << 8) | b;
    case (hs_phase)
      P_FIXED, P_SID, P_CS, P_CM, P_EXT_SKIP, P_NAME_SKIP: begin
        skip_left = (skip_left - 1) & POS_MASK;
        if (skip_left == 0) after_skip(hs_phase);
      end
      P_SID_LEN:
        if (body_end < p + b + 2) decide(ST_BAD);
        else skip_or_go(b, P_SID);
      P_CS0, P_EXTS0, P_EXT_T0, P_EXT_L0, P_SNI_L0, P_LIST0: begin
        accum = b;
        hs_phase = hello_phase_e'(hs_phase + 1);
      end
      P_CS1:
        if (body_end < p + n + 1) decide(ST_BAD);
        else skip_or_go(n, P_CS);
      P_CM_LEN:
        if (body_end < p + b) decide(ST_BAD);
        else skip_or_go(b, P_CM);
      P_EXTS1:
        if (body_end < p + n) decide(ST_BAD);
        else begin
          exts_end = p + n;
          ext_loop();
        end
      P_EXT_T1: hs_phase = (n == 0) ? P_SNI_L0 : P_EXT_L0;
      P_EXT_L1:
        if (p + n > exts_end) decide(ST_BAD);
        else skip_or_go(n, P_EXT_SKIP);
      P_SNI_L1:
        if (p + n > exts_end || n < 2) decide(ST_BAD);
        else begin
          ext_end = p + n;
          hs_phase = P_LIST0;
        end
      P_LIST1: begin
        list_end = p + n;
        if (list_end > ext_end) decide(ST_BAD);
        else name_loop();
      end
      P_NAME_TYPE: begin
        accum = b << 16;
        hs_phase = P_NAME_L0;
      end
      P_NAME_L0: begin
        accum = accum | (b << 8);
        hs_phase = P_NAME_L1;
      end
      P_NAME_L1: begin
        accum = accum | b;
        n = accum & 32'hFFFF;
        if (p + n > list_end) decide(ST_BAD);
        else if ((accum >> 16) == 0) begin
          value_end = p + n;
          name_cnt = 0; space_end = 0; dot_end = 0; nondot_end = 0;
          if (n == 0) finish_name();
          else hs_phase = P_NAME_VALUE;
        end else skip_or_go(n, P_NAME_SKIP);
      end
      P_NAME_VALUE: begin
        // Trailing blanks are cut first, then trailing dots.
        name_cnt = (name_cnt + 1) & 32'hFFFF;
        if (b != CH_SPACE && b != CH_TAB && b != CH_CR) begin
          space_end = name_cnt;
          dot_end = (b != CH_DOT) ? name_cnt : nondot_end;
        end
        if (b != CH_DOT) nondot_end = name_cnt;
        if (p == value_end) finish_name();
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // Run one accepted byte through the predictor and queue its results.
  function automatic void parse_step(bit [7:0] d, bit last);
    bit [31:0] b;
    bit [31:0] len;
    bit        fire;
    bit [1:0]  st;
    result_t   r;
    result_t   outs[$];
    b = d;
    fire = 0;
    case (hs_phase)
      P_HDR0: begin
        if (d != HELLO_TYPE) begin
          dec_flag = 1;
          dec_status = ST_BAD;
        end
        hs_phase = P_HDR1;
      end
      P_HDR1: begin
        accum = b;
        hs_phase = P_HDR2;
      end
      P_HDR2: begin
        accum = (accum << 8) | b;
        hs_phase = P_HDR3;
      end
      P_HDR3: begin
        len = ((accum & 32'hFFFF) << 8) | b;
        if (dec_flag || len > POS_MASK) begin
          decide(ST_BAD);
          fire = 1;
        end else begin
          body_end = len;
          if (len < MIN_BODY) decide(ST_BAD);
          else skip_or_go(FIXED_LEN, P_FIXED);
          fire = (len == 0);
        end
      end
      P_DONE: ;
      default: begin
        if (consume_body(b)) begin
          r = '0;
          r.host_byte = d;
          outs.push_back(r);
        end
        fire = (body_pos == body_end);
      end
    endcase
    if (fire && !verdict_done) begin
      st = dec_flag ? dec_status : ST_BAD;
      r = '0;
      r.is_verdict = 1;
      r.status = st;
      r.host_length = (st == ST_OK) ? dot_end[15:0] : 16'd0;
      outs.push_back(r);
      verdict_done = 1;
      hs_phase = P_DONE;
    end
    if (last) begin
      if (!verdict_done) begin
        r = '0;
        r.is_verdict = 1;
        r.status = ST_NEED_MORE;
        outs.push_back(r);
      end
      clear_parse();
    end
    if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1;
    foreach (outs[i]) results_due.push_back(outs[i]);
  endfunction

  // ------------------------------------------------------------------------
  // Message builders
  // ------------------------------------------------------------------------
  function automatic void put16(ref bit [7:0] q[$], input int v);
    q.push_back(v[15:8]);
    q.push_back(v[7:0]);
  endfunction

  function automatic void put_rand(ref bit [7:0] q[$], input int k);
    repeat (k) q.push_back($urandom);
  endfunction

  function automatic void queue_bytes(bit [7:0] msg[$]);
    msg_byte_t m;
    foreach (msg[i]) begin
      m.data = msg[i];
      m.last = (i == msg.size() - 1);
      byte_q.push_back(m);
    end
  endfunction

  // Build one ClientHello, then maybe break it; return its byte count.
  function automatic int add_hello();
    bit [7:0] nm[$];
    bit [7:0] lst[$];
    bit [7:0] exts[$];
    bit [7:0] msg[$];
    int nl;
    int k;
    int shape;
    nl = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 12);
    repeat (nl) begin
      case ($urandom_range(0, 7))
        0: nm.push_back(CH_DOT);
        1: nm.push_back(CH_SPACE);
        2: nm.push_back(CH_TAB);
        3: nm.push_back(CH_CR);
        4: nm.push_back($urandom);
        default: nm.push_back(8'h61 + $urandom_range(0, 25));
      endcase
    end
    // Server name list: an optional foreign entry ahead of host_name.
    if ($urandom_range(0, 3) == 0) begin
      lst.push_back($urandom_range(1, 255));
      k = $urandom_range(0, 3);
      put16(lst, k);
      put_rand(lst, k);
    end
    lst.push_back(8'h00);
    put16(lst, nl);
    foreach (nm[i]) lst.push_back(nm[i]);
    if ($urandom_range(0, 3) == 0) begin
      lst.push_back($urandom);
      put16(lst, 1);
      put_rand(lst, 1);
    end
    // Extensions around the server_name one.
    if ($urandom_range(0, 2) == 0) begin
      put16(exts, $urandom_range(1, 65535));
      k = $urandom_range(0, 4);
      put16(exts, k);
      put_rand(exts, k);
    end
    put16(exts, 0);
    put16(exts, lst.size() + 2);
    put16(exts, lst.size());
    foreach (lst[i]) exts.push_back(lst[i]);
    if ($urandom_range(0, 3) == 0) begin
      put16(exts, $urandom_range(1, 65535));
      put16(exts, 2);
      put_rand(exts, 2);
    end
    // Body: version and random, session id, suites, compression.
    put_rand(msg, 34);
    k = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(0, 3);
    msg.push_back(k);
    put_rand(msg, k);
    k = 2 * $urandom_range(0, 3);
    put16(msg, k);
    put_rand(msg, k);
    k = $urandom_range(0, 2);
    msg.push_back(k);
    put_rand(msg, k);
    if ($urandom_range(0, 7) != 0) begin
      put16(msg, exts.size());
      foreach (exts[i]) msg.push_back(exts[i]);
    end
    k = msg.size();
    msg.push_front(k[7:0]);
    msg.push_front(k[15:8]);
    msg.push_front(k[23:16]);
    msg.push_front(HELLO_TYPE);
    // Mostly well formed; the rest corrupted, cut, padded or pure noise.
    shape = $urandom_range(0, 9);
    case (shape)
      5: begin
        k = $urandom_range(0, msg.size() - 1);
        msg[k] = msg[k] ^ $urandom_range(1, 255);
      end
      6: msg = msg[0:$urandom_range(0, msg.size() - 2)];
      7: put_rand(msg, $urandom_range(1, 4));
      8: begin
        msg.delete();
        put_rand(msg, $urandom_range(1, 6));
      end
      default: ;
    endcase
    queue_bytes(msg);
    return msg.size();
  endfunction

  // ------------------------------------------------------------------------
  // Clock and reset
  // ------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Byte driver: change inputs on the falling edge, hold until taken
  // ------------------------------------------------------------------------
  int in_gap = 0;

  always @(negedge clk) begin
    msg_byte_t m;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_took) begin
      in_took = 0;
      if (in_gap > 0) begin
        // Idle between transactions.
        in_gap--;
        in_valid <= 0;
      end else if (byte_q.size() > 0) begin
        m = byte_q.pop_front();
        in_valid <= 1;
        data_byte <= m.data;
        last_byte <= m.last;
        // Alternate idle stretches with back-to-back bursts.
        in_gap = ((in_count >> 6) & 1) ? $urandom_range(0, 3) : 0;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off to fill the
  // output queue and push back on the byte channel
  // ------------------------------------------------------------------------
  int out_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (!hold_done && in_count >= 150) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: sample on the rising edge, predict and check
  // ------------------------------------------------------------------------
  task automatic report_field(string field, int want, int got);
    $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, results_due.size());
      $display("== FAIL ==");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) cap_shadow = cfg_data;
      if (in_valid && in_ready) begin
        parse_step(data_byte, last_byte);
        in_took = 1;
        in_count++;
      end
      if (out_valid && out_ready) begin
        out_count++;
        out_gap = ((out_count >> 5) & 1) ? $urandom_range(0, 3) : 0;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual verdict=%0b byte=%0h",
                   $time, is_verdict, host_byte);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (is_verdict !== want.is_verdict)
            report_field("is_verdict", want.is_verdict, is_verdict);
          if (host_byte !== want.host_byte)
            report_field("host_byte", want.host_byte, host_byte);
          if (status !== want.status)
            report_field("status", want.status, status);
          if (host_length !== want.host_length)
            report_field("host_length", want.host_length, host_length);
          if (last_of_run !== want.last_of_run)
            report_field("last_of_run", want.last_of_run, last_of_run);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus sequence
  // ------------------------------------------------------------------------
  // Hold until every byte is taken and every result has come, then let the
  // parser settle, since a byte may cause no result.
  task automatic wait_drained();
    while (byte_q.size() > 0 || in_valid || results_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(bit [15:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic run_messages();
    int sent;
    sent = 0;
    while (sent < 80) sent += add_hello();
  endtask

  initial begin
    bit [15:0] caps[4];
    rst = 1;
    in_valid = 0;
    data_byte = 0;
    last_byte = 0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_data = 0;
    clear_parse();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Header corner cases: wrong type, empty body, body too short,
    // cut inside the header, largest length cut short, a lone byte.
    queue_bytes('{8'hFF, 8'h00, 8'h00, 8'h30});
    queue_bytes('{HELLO_TYPE, 8'h00, 8'h00, 8'h00});
    queue_bytes('{HELLO_TYPE, 8'h00, 8'h00, 8'h22, 8'hAA, 8'h55});
    queue_bytes('{HELLO_TYPE, 8'hFF});
    queue_bytes('{HELLO_TYPE, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    queue_bytes('{8'h00});
    wait_drained();

    // Random traffic at the reset capacity, then at written settings.
    run_messages();
    caps = '{16'd1, 16'd65535, 16'($urandom_range(2, 16)), CAP_RESET};
    foreach (caps[i]) begin
      wait_drained();
      write_capacity(caps[i]);
      run_messages();
    end

    wait_drained();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
